FILE: hw/rtl/wbc_pkg.sv
// wbc_pkg: request and result types, command codes and matcher types
// for the word break checker. depends on nothing.
package wbc_pkg;

  typedef enum logic [1:0] {
    CMD_DICT_CHAR  = 2'd0,
    CMD_TEXT_CHAR  = 2'd1,
    CMD_END_TEXT   = 2'd2,
    CMD_CLEAR_DICT = 2'd3
  } wbc_cmd_t;

  typedef struct packed {
    wbc_cmd_t    command;
    logic [7:0]  char_code;
    logic        word_end;
  } wbc_item_t;

  typedef struct packed {
    logic breakable;
    logic overflow;
  } wbc_result_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_LEN,
    M_START,
    M_REACH,
    M_CMP,
    M_CHK,
    M_DONE
  } wbc_mstate_t;

  typedef struct packed {
    logic done;
    logic hit;
  } wbc_match_t;

endpackage

FILE: hw/rtl/wbc_ram.sv
// wbc_ram: generic single write port, single read port ram with registered read.
// depends on nothing.
module wbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/wbc_matcher.sv
// wbc_matcher: sequencer that tries the stored words in turn against the text tail
// until one matches, one character compare at a time. depends on wbc_pkg.
module wbc_matcher import wbc_pkg::*; #(
  parameter int MAX_TEXT     = 512,
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [$clog2(MAX_TEXT+1)-1:0]  end_pos,
  input  logic [$clog2(MAX_WORDS+1)-1:0] dict_count,
  output logic [((MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1)-1:0] len_raddr,
  input  logic [$clog2(MAX_WORD_LEN+1)-1:0] len_rdata,
  output logic [$clog2(MAX_TEXT+1)-1:0]  reach_raddr,
  input  logic                 reach_rdata,
  output logic                 reach_we,
  output logic [$clog2(MAX_TEXT+1)-1:0]  reach_waddr,
  output logic                 reach_wdata,
  output logic [$clog2(MAX_TEXT)-1:0]    text_raddr,
  input  logic [7:0]           text_rdata,
  output logic [((MAX_WORDS*MAX_WORD_LEN > 1) ? $clog2(MAX_WORDS*MAX_WORD_LEN) : 1)-1:0]
                               dict_raddr,
  input  logic [7:0]           dict_rdata,
  output wbc_match_t           status
);

  localparam int TW  = $clog2(MAX_TEXT + 1);
  localparam int TXA = $clog2(MAX_TEXT);
  localparam int WN  = $clog2(MAX_WORDS + 1);
  localparam int WI  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW  = $clog2(MAX_WORD_LEN + 1);
  localparam int DA  = (MAX_WORDS * MAX_WORD_LEN > 1) ? $clog2(MAX_WORDS * MAX_WORD_LEN) : 1;

  wbc_mstate_t   state, state_next;
  logic [WN-1:0] w, w_next;
  logic [LW-1:0] k, k_next;
  logic [LW-1:0] len, len_next;
  logic [TW-1:0] start_pos, start_pos_next;
  logic [TW-1:0] end_r, end_r_next;
  logic          hit, hit_next;

  logic [TW-1:0] start_calc;
  logic [TW-1:0] text_sum;
  logic [WN-1:0] w_inc;
  logic          too_long;

  assign start_calc = end_r - TW'(len_rdata);
  assign text_sum   = start_pos + TW'(k);
  assign w_inc      = w + WN'(1);
  assign too_long   = {{LW{1'b0}}, end_r} < {{TW{1'b0}}, len_rdata};

  assign len_raddr   = w[WI-1:0];
  assign reach_raddr = start_calc;
  assign text_raddr  = text_sum[TXA-1:0];
  assign dict_raddr  = DA'(w[WI-1:0]) * DA'(MAX_WORD_LEN) + DA'(k);
  assign reach_we    = (state == M_DONE);
  assign reach_waddr = end_r;
  assign reach_wdata = hit;
  assign status.done = (state == M_DONE);
  assign status.hit  = hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
    w         <= w_next;
    k         <= k_next;
    len       <= len_next;
    start_pos <= start_pos_next;
    end_r     <= end_r_next;
    hit       <= hit_next;
  end

  always_comb begin
    state_next     = state;
    w_next         = w;
    k_next         = k;
    len_next       = len;
    start_pos_next = start_pos;
    end_r_next     = end_r;
    hit_next       = hit;
    unique case (state)
      M_IDLE: begin
        if (start) begin
          end_r_next = end_pos;
          w_next     = '0;
          hit_next   = 1'b0;
          state_next = (dict_count == '0) ? M_DONE : M_LEN;
        end
      end
      M_LEN: state_next = M_START;
      M_START: begin
        if (len_rdata == '0 || too_long) begin
          // skip to next word
          if (w_inc >= dict_count) state_next = M_DONE;
          else begin
            w_next     = w_inc;
            state_next = M_LEN;
          end
        end else begin
          len_next       = len_rdata;
          start_pos_next = start_calc;
          k_next         = '0;
          state_next     = M_REACH;
        end
      end
      M_REACH: begin
        // position zero is always reachable
        if (start_pos == '0 || reach_rdata) state_next = M_CMP;
        else if (w_inc >= dict_count) state_next = M_DONE;
        else begin
          w_next     = w_inc;
          state_next = M_LEN;
        end
      end
      M_CMP: state_next = M_CHK;
      M_CHK: begin
        if (text_rdata != dict_rdata) begin
          if (w_inc >= dict_count) state_next = M_DONE;
          else begin
            w_next     = w_inc;
            state_next = M_LEN;
          end
        end else if (k + LW'(1) == len) begin
          hit_next   = 1'b1;
          state_next = M_DONE;
        end else begin
          k_next     = k + LW'(1);
          state_next = M_CMP;
        end
      end
      M_DONE: state_next = M_IDLE;
      default: state_next = M_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/word_break_checker.sv
// word_break_checker: top level with request decode, dictionary loading,
// storage rams and the result register. depends on wbc_pkg, wbc_ram, wbc_matcher.
//
// requests come in on item (valid/stall). dictionary characters, end-of-text and
// clear-dictionary requests are handled on acceptance. a text character that fits
// runs the matcher, which walks the committed words until one matches: per word it
// fetches the length (M_LEN, M_START), then the reachability at its start (M_REACH)
// unless the word is skipped as empty or longer than the text, then compares its
// characters one at a time (M_CMP, M_CHK). the block stays busy until the matcher is
// done; the single compare path runs through the text and dictionary ram read
// ports.
// only end-of-text gives a result, in the cycle after acceptance, held in the
// result register (valid/stall) until taken; new requests are still accepted
// while it waits unless the receiver stalls it.
// reset empties the dictionary, the text and the overflow flag; rams need no
// clearing since only written entries are ever read.
module word_break_checker import wbc_pkg::*; #(
  parameter int MAX_TEXT     = 512,
  parameter int MAX_WORDS    = 64,
  parameter int MAX_WORD_LEN = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  wbc_item_t   item,
  output logic        result_valid,
  input  logic        result_stall,
  output wbc_result_t result
);

  localparam int TW  = $clog2(MAX_TEXT + 1);
  localparam int TXA = $clog2(MAX_TEXT);
  localparam int WN  = $clog2(MAX_WORDS + 1);
  localparam int WI  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int LW  = $clog2(MAX_WORD_LEN + 1);
  localparam int DA  = (MAX_WORDS * MAX_WORD_LEN > 1) ? $clog2(MAX_WORDS * MAX_WORD_LEN) : 1;

  logic          busy;
  logic [WN-1:0] dict_count;
  logic [LW-1:0] loading_len;
  logic          loading_bad;
  logic [TW-1:0] text_len;
  logic          last_reach;
  logic          overflow_flag;

  logic          accept;
  logic          d_ok, d_bad_after, d_commit;
  logic [LW-1:0] d_len_after;
  logic          t_ok;

  logic [WI-1:0]  len_raddr;
  logic [LW-1:0]  len_rdata;
  logic [TW-1:0]  reach_raddr, reach_waddr;
  logic           reach_rdata, reach_we, reach_wdata;
  logic [TXA-1:0] text_raddr;
  logic [7:0]     text_rdata, dict_rdata;
  logic [DA-1:0]  dict_raddr, dict_waddr;
  wbc_match_t     m_stat;

  assign item_stall = busy | (result_valid & result_stall);
  assign accept     = item_valid & ~item_stall;

  assign d_ok        = ~loading_bad && (dict_count < WN'(MAX_WORDS))
                       && (loading_len < LW'(MAX_WORD_LEN));
  assign d_len_after = d_ok ? loading_len + LW'(1) : loading_len;
  assign d_bad_after = loading_bad | ~d_ok;
  assign d_commit    = item.word_end && !d_bad_after && (d_len_after != '0)
                       && (dict_count < WN'(MAX_WORDS));
  assign dict_waddr  = DA'(dict_count[WI-1:0]) * DA'(MAX_WORD_LEN) + DA'(loading_len);
  assign t_ok        = text_len < TW'(MAX_TEXT);

  wbc_ram #(.WIDTH(8), .DEPTH(MAX_WORDS * MAX_WORD_LEN)) u_dict_ram (
    .clk   (clk),
    .we    (accept && item.command == CMD_DICT_CHAR && d_ok),
    .waddr (dict_waddr),
    .wdata (item.char_code),
    .raddr (dict_raddr),
    .rdata (dict_rdata)
  );

  wbc_ram #(.WIDTH(LW), .DEPTH(MAX_WORDS)) u_len_ram (
    .clk   (clk),
    .we    (accept && item.command == CMD_DICT_CHAR && d_commit),
    .waddr (dict_count[WI-1:0]),
    .wdata (d_len_after),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

  wbc_ram #(.WIDTH(8), .DEPTH(MAX_TEXT)) u_text_ram (
    .clk   (clk),
    .we    (accept && item.command == CMD_TEXT_CHAR && t_ok),
    .waddr (text_len[TXA-1:0]),
    .wdata (item.char_code),
    .raddr (text_raddr),
    .rdata (text_rdata)
  );

  wbc_ram #(.WIDTH(1), .DEPTH(MAX_TEXT + 1)) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (reach_waddr),
    .wdata (reach_wdata),
    .raddr (reach_raddr),
    .rdata (reach_rdata)
  );

  wbc_matcher #(
    .MAX_TEXT     (MAX_TEXT),
    .MAX_WORDS    (MAX_WORDS),
    .MAX_WORD_LEN (MAX_WORD_LEN)
  ) u_matcher (
    .clk         (clk),
    .rst         (rst),
    .start       (accept && item.command == CMD_TEXT_CHAR && t_ok),
    .end_pos     (text_len + TW'(1)),
    .dict_count  (dict_count),
    .len_raddr   (len_raddr),
    .len_rdata   (len_rdata),
    .reach_raddr (reach_raddr),
    .reach_rdata (reach_rdata),
    .reach_we    (reach_we),
    .reach_waddr (reach_waddr),
    .reach_wdata (reach_wdata),
    .text_raddr  (text_raddr),
    .text_rdata  (text_rdata),
    .dict_raddr  (dict_raddr),
    .dict_rdata  (dict_rdata),
    .status      (m_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      dict_count    <= '0;
      loading_len   <= '0;
      loading_bad   <= 1'b0;
      text_len      <= '0;
      last_reach    <= 1'b1;
      overflow_flag <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      if (m_stat.done) begin
        busy       <= 1'b0;
        text_len   <= text_len + TW'(1);
        last_reach <= m_stat.hit;
      end
      if (accept) begin
        unique case (item.command)
          CMD_DICT_CHAR: begin
            if (!d_ok) overflow_flag <= 1'b1;
            if (item.word_end) begin
              if (d_commit) dict_count <= dict_count + WN'(1);
              loading_len <= '0;
              loading_bad <= 1'b0;
            end else begin
              loading_len <= d_len_after;
              loading_bad <= d_bad_after;
            end
          end
          CMD_TEXT_CHAR: begin
            if (t_ok) busy <= 1'b1;
            else overflow_flag <= 1'b1;
          end
          CMD_END_TEXT: begin
            result_valid     <= 1'b1;
            result.breakable <= last_reach;
            result.overflow  <= overflow_flag;
            text_len         <= '0;
            last_reach       <= 1'b1;
            overflow_flag    <= 1'b0;
          end
          CMD_CLEAR_DICT: begin
            dict_count  <= '0;
            loading_len <= '0;
            loading_bad <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  a_text_len_range: assert property (@(posedge clk) disable iff (rst)
    text_len <= TW'(MAX_TEXT)) else $error("text length beyond capacity");

  a_dict_count_range: assert property (@(posedge clk) disable iff (rst)
    dict_count <= WN'(MAX_WORDS)) else $error("word count beyond capacity");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    m_stat.done |-> busy) else $error("match finished with no text request");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

endmodule
